/* design/fixed_partition_fit_allocator_macros.svh */
// Assertion helpers used by the checker file.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FPFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fpfa assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FPFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fpfa assertion failed");

`endif

/* design/fpfa_pkg.sv */
`timescale 1ns / 1ps

package fpfa_pkg;

  // Field widths of the stream payloads
  localparam int unsigned EntryIdxWidth  = 4;
  localparam int unsigned SizeFieldWidth = 16;
  localparam int unsigned InDataWidth    = 24;
  localparam int unsigned OutDataWidth   = 8;

  // Item kinds carried in tuser
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_FIT_MODE    = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // Selection policy; code 3 behaves as first fit
  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  // Control handed to the compare unit with each candidate
  typedef struct packed {
    fit_mode_e mode;
    logic      found;
    logic      occupied;
  } cmp_ctl_t;

endpackage

/* design/fpfa_fit_cmp.sv */
`timescale 1ns / 1ps

module fpfa_fit_cmp #(
  parameter int unsigned SIZE_WIDTH = 16
) (
  input  logic [SIZE_WIDTH-1:0] cand_size_i,
  input  logic [SIZE_WIDTH-1:0] req_size_i,
  input  logic [SIZE_WIDTH-1:0] best_size_i,
  input  fpfa_pkg::cmp_ctl_t    ctl_i,
  output logic                  take_o
);

  logic fits;
  logic smaller;
  logic larger;

  // Candidate is free and large enough
  assign fits    = !ctl_i.occupied && (cand_size_i >= req_size_i);
  assign smaller = cand_size_i < best_size_i;
  assign larger  = cand_size_i > best_size_i;

  // Replace the held pick per policy; strict compares keep the lowest index on ties
  always_comb begin
    case (ctl_i.mode)
      fpfa_pkg::FIT_FIRST: take_o = fits && !ctl_i.found;
      fpfa_pkg::FIT_BEST:  take_o = fits && (!ctl_i.found || smaller);
      fpfa_pkg::FIT_WORST: take_o = fits && (!ctl_i.found || larger);
      default:             take_o = fits && !ctl_i.found;
    endcase
  end

endmodule

/* design/fixed_partition_fit_allocator.sv */
// The block stays ready after a load item and can take an item every cycle while idle.
// A request scans one table entry per cycle through a shared compare unit fed by the
// size memory's registered read port; no new item is taken until the result has been
// moved into the output register, which waits while a held result is stalled.
// rst_ni is asynchronous, active low: all entries free, fit_mode 0, block_count 16.
// Partition sizes are not cleared and hold no value until loaded.
`timescale 1ns / 1ps

module fixed_partition_fit_allocator #(
  parameter int unsigned MAX_PARTITIONS = 16,
  parameter int unsigned SIZE_WIDTH     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] entry_index, [19:4] size_value, [23:20] zero
  input  logic [23:0] s_axis_tdata,
  // [0] opcode
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] chosen_index, [7:4] zero
  output logic [7:0]  m_axis_tdata,
  // [0] granted
  output logic        m_axis_tuser,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTITIONS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Configuration registers
  logic [1:0] fit_mode_q;
  logic [4:0] block_count_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= 2'd0;
      block_count_q <= 5'd16;
    end else if (cfg_wr) begin
      if (paddr[2] == fpfa_pkg::REG_FIT_MODE) begin
        fit_mode_q <= pwdata[1:0];
      end else begin
        block_count_q <= pwdata[4:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == fpfa_pkg::REG_BLOCK_COUNT) begin
      prdata = {27'd0, block_count_q};
    end else begin
      prdata = {30'd0, fit_mode_q};
    end
  end

  // Unpack the input transfer
  logic [31:0]           idx_ext;
  logic [31:0]           size_ext;
  logic [IW-1:0]         load_idx;
  logic [SIZE_WIDTH-1:0] in_size;
  logic                  load_ok;
  logic                  in_xfer;
  logic                  is_load;
  logic                  is_req;

  assign idx_ext  = {28'd0, s_axis_tdata[3:0]};
  assign size_ext = {16'd0, s_axis_tdata[19:4]};
  assign load_idx = idx_ext[IW-1:0];
  assign in_size  = size_ext[SIZE_WIDTH-1:0];
  assign load_ok  = idx_ext < MAX_PARTITIONS;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign is_load  = in_xfer && (s_axis_tuser == fpfa_pkg::OP_LOAD);
  assign is_req   = in_xfer && (s_axis_tuser == fpfa_pkg::OP_REQUEST);

  // Sequencer registers
  state_e                  state_q, state_d;
  logic [MAX_PARTITIONS-1:0] occ_q, occ_d;
  logic [CW-1:0]           iss_q, iss_d;
  logic [CW-1:0]           count_q, count_d;
  logic                    eval_vld_q, eval_vld_d;
  logic [IW-1:0]           eval_idx_q, eval_idx_d;
  logic [SIZE_WIDTH-1:0]   req_q, req_d;
  logic [SIZE_WIDTH-1:0]   best_q, best_d;
  logic [IW-1:0]           pick_q, pick_d;
  logic                    found_q, found_d;
  logic                    last_q, last_d;
  fpfa_pkg::fit_mode_e     mode_q, mode_d;
  logic                    m_valid_q, m_valid_d;
  logic                    m_user_q, m_user_d;
  logic [7:0]              m_data_q, m_data_d;

  // Size memory with a registered read port
  logic [SIZE_WIDTH-1:0] mem [MAX_PARTITIONS];
  logic [SIZE_WIDTH-1:0] rd_q;
  logic [IW-1:0]         rd_addr;

  assign rd_addr = iss_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (is_load && load_ok) begin
      mem[load_idx] <= in_size;
    end
    rd_q <= mem[rd_addr];
  end

  // Shared compare unit
  fpfa_pkg::cmp_ctl_t cmp_ctl;
  logic               take;

  assign cmp_ctl.mode     = mode_q;
  assign cmp_ctl.found    = found_q;
  assign cmp_ctl.occupied = occ_q[eval_idx_q];

  fpfa_fit_cmp #(
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_cmp (
    .cand_size_i(rd_q),
    .req_size_i (req_q),
    .best_size_i(best_q),
    .ctl_i      (cmp_ctl),
    .take_o     (take)
  );

  logic [31:0] bc_ext;
  logic [31:0] pick_ext;
  logic        out_free;

  assign bc_ext        = {27'd0, block_count_q};
  assign pick_ext      = 32'(pick_q);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Next-state logic
  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    iss_d      = iss_q;
    count_d    = count_q;
    eval_vld_d = 1'b0;
    eval_idx_d = eval_idx_q;
    req_d      = req_q;
    best_d     = best_q;
    pick_d     = pick_q;
    found_d    = found_q;
    last_d     = last_q;
    mode_d     = mode_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_user_d   = m_user_q;
    m_data_d   = m_data_q;

    case (state_q)
      ST_IDLE: begin
        // free a loaded entry
        if (is_load && load_ok) begin
          occ_d[load_idx] = 1'b0;
        end
        // latch the request and start the scan
        if (is_req) begin
          req_d   = in_size;
          last_d  = s_axis_tlast;
          mode_d  = fpfa_pkg::fit_mode_e'(fit_mode_q);
          found_d = 1'b0;
          pick_d  = '0;
          iss_d   = '0;
          count_d = (bc_ext > MAX_PARTITIONS) ? CW'(MAX_PARTITIONS) : CW'(bc_ext);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // evaluate the entry read last cycle
        if (eval_vld_q && take) begin
          found_d = 1'b1;
          pick_d  = eval_idx_q;
          best_d  = rd_q;
        end
        // issue the next read or finish
        if (iss_q < count_q) begin
          eval_vld_d = 1'b1;
          eval_idx_d = iss_q[IW-1:0];
          iss_d      = iss_q + 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // deliver the result once the output register is free
        if (out_free) begin
          m_valid_d = 1'b1;
          m_user_d  = found_q;
          m_data_d  = found_q ? {4'd0, pick_ext[3:0]} : 8'd0;
          if (found_q) begin
            occ_d[pick_q] = 1'b1;
          end
          if (last_q) begin
            occ_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      occ_q      <= '0;
      iss_q      <= '0;
      count_q    <= '0;
      eval_vld_q <= 1'b0;
      eval_idx_q <= '0;
      req_q      <= '0;
      best_q     <= '0;
      pick_q     <= '0;
      found_q    <= 1'b0;
      last_q     <= 1'b0;
      mode_q     <= fpfa_pkg::FIT_FIRST;
      m_valid_q  <= 1'b0;
      m_user_q   <= 1'b0;
      m_data_q   <= '0;
    end else begin
      state_q    <= state_d;
      occ_q      <= occ_d;
      iss_q      <= iss_d;
      count_q    <= count_d;
      eval_vld_q <= eval_vld_d;
      eval_idx_q <= eval_idx_d;
      req_q      <= req_d;
      best_q     <= best_d;
      pick_q     <= pick_d;
      found_q    <= found_d;
      last_q     <= last_d;
      mode_q     <= mode_d;
      m_valid_q  <= m_valid_d;
      m_user_q   <= m_user_d;
      m_data_q   <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* design/fpfa_checker.sv */
`timescale 1ns / 1ps
`include "fixed_partition_fit_allocator_macros.svh"

module fpfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser
);

  logic       req_xfer;
  logic       out_deny;
  logic       out_stall;
  logic [8:0] out_bus;

  assign req_xfer  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == fpfa_pkg::OP_REQUEST);
  assign out_deny  = m_axis_tvalid && !m_axis_tuser;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_bus   = {m_axis_tuser, m_axis_tdata};

  // A request transfer closes the input until its scan ends
  `FPFA_ASSERT_NXT(a_req_blocks_input, clk_i, rst_ni, req_xfer, !s_axis_tready)

  // A refusal carries index zero
  `FPFA_ASSERT_IMP(a_deny_index_zero, clk_i, rst_ni, out_deny, m_axis_tdata == 8'd0)

  // A stalled result holds
  `FPFA_ASSERT_NXT(a_result_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_bus))

  // A new result shows only while the input is closed by a scan
  `FPFA_ASSERT_IMP(a_result_after_scan, clk_i, rst_ni, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (.*);

/* bench/fixed_partition_fit_allocator_tb.sv */
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_tb;

  localparam int unsigned NumEntries    = 16;
  localparam int unsigned PhaseCount    = 10;
  localparam int unsigned PhaseItems    = 80;
  localparam int unsigned SettleCycles  = 24;
  localparam int unsigned QuietLimit    = 5000;
  localparam logic [2:0]  AddrFitMode   = {fpfa_pkg::REG_FIT_MODE, 2'b00};
  localparam logic [2:0]  AddrBlockCnt  = {fpfa_pkg::REG_BLOCK_COUNT, 2'b00};

  // Mirror of the allocator: partition table, occupied flags and registers
  class alloc_scoreboard;
    typedef struct {
      bit       granted;
      bit [3:0] index;
    } grant_t;

    bit [15:0] part_size [NumEntries];
    bit [15:0] busy;
    bit [1:0]  mode;
    bit [4:0]  count_reg;
    grant_t    expected_grants [$];
    int        errors;

    function new();
      busy      = '0;
      mode      = fpfa_pkg::FIT_FIRST;
      count_reg = 5'd16;
      errors    = 0;
    endfunction

    function void set_reg(logic [2:0] addr, logic [31:0] value);
      if (addr[2] == fpfa_pkg::REG_FIT_MODE) mode = value[1:0];
      else count_reg = value[4:0];
    endfunction

    // Apply one accepted transfer; a request queues its expected grant
    function void predict_grant(bit op, bit [3:0] idx, bit [15:0] size, bit last);
      int     limit;
      bit     found;
      int     pick;
      grant_t res;
      if (op == fpfa_pkg::OP_LOAD) begin
        part_size[idx] = size;
        busy[idx]      = 1'b0;
        return;
      end
      limit = (count_reg > NumEntries) ? NumEntries : count_reg;
      found = 1'b0;
      pick  = 0;
      for (int j = 0; j < limit; j++) begin
        if (busy[j] || part_size[j] < size) continue;
        if (!found) begin
          found = 1'b1;
          pick  = j;
          if (mode != fpfa_pkg::FIT_BEST && mode != fpfa_pkg::FIT_WORST) break;
        end else if (mode == fpfa_pkg::FIT_BEST && part_size[j] < part_size[pick]) begin
          pick = j;
        end else if (mode == fpfa_pkg::FIT_WORST && part_size[j] > part_size[pick]) begin
          pick = j;
        end
      end
      if (found) busy[pick] = 1'b1;
      res.granted = found;
      res.index   = found ? pick[3:0] : 4'd0;
      expected_grants.push_back(res);
      if (last) busy = '0;
    endfunction

    function void check_grant(bit granted, bit [3:0] idx);
      grant_t exp_res;
      if (expected_grants.size() == 0) begin
        $error("unexpected result: granted=%0d chosen_index=%0d", granted, idx);
        errors++;
        return;
      end
      exp_res = expected_grants.pop_front();
      if (granted !== exp_res.granted) begin
        $error("granted: expected %0d, actual %0d", exp_res.granted, granted);
        errors++;
      end
      if (idx !== exp_res.index) begin
        $error("chosen_index: expected %0d, actual %0d", exp_res.index, idx);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  alloc_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  int phase_mode [PhaseCount]  = '{0, 1, 2, 3, 1, 2, 0, 1, 2, 1};
  int phase_count [PhaseCount] = '{16, 16, 16, 16, 0, 31, 1, 17, 8, 5};

  fixed_partition_fit_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // Randomly stall the result side
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_grant(m_axis_tuser, m_axis_tdata[3:0]);
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("fixed_partition_fit_allocator verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item, hold it until its transfer, then note it
  task automatic send_item(bit op, bit [3:0] idx, bit [15:0] size, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'd0, size, idx};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.predict_grant(op, idx, size, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid, wait for all results, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_grants.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(addr, value);
  endtask

  function automatic bit [15:0] load_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 16'($urandom_range(63));
    if (r < 90) return 16'($urandom);
    return (r < 95) ? 16'd0 : 16'hFFFF;
  endfunction

  // Request sizes cluster around loaded sizes so that fits are close
  function automatic bit [15:0] request_size();
    int unsigned r;
    bit [15:0]   base;
    bit [15:0]   off;
    r    = $urandom_range(99);
    base = sb.part_size[$urandom_range(NumEntries - 1)];
    off  = 16'($urandom_range(2));
    if (r < 50) return (base > off) ? base - off : 16'd0;
    if (r < 65) return base + 16'd1;
    if (r < 80) return 16'($urandom_range(63));
    return 16'($urandom);
  endfunction

  // Either a noise item or a run of loads followed by requests ending in last
  task automatic run_sequence();
    int unsigned nload;
    int unsigned nreq;
    if ($urandom_range(9) == 0) begin
      send_item(1'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
      return;
    end
    nload = $urandom_range(4);
    nreq  = $urandom_range(1, 8);
    repeat (nload) send_item(fpfa_pkg::OP_LOAD, 4'($urandom), load_size(), 1'($urandom));
    for (int k = 0; k < nreq; k++)
      send_item(fpfa_pkg::OP_REQUEST, 4'($urandom), request_size(), k == nreq - 1);
  endtask

  initial begin
    int unsigned target;
    bit [15:0]   seed_sizes [NumEntries];
    seed_sizes = '{16'd0, 16'hFFFF, 16'd1, 16'd100, 16'd100, 16'd50, 16'hFFFE, 16'd200,
                   16'd8, 16'd8, 16'h8000, 16'd3, 16'd1000, 16'd7, 16'd150, 16'd9};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fill the whole table first so that no request scans an unloaded entry
    for (int e = 0; e < NumEntries; e++) begin
      send_item(fpfa_pkg::OP_LOAD, e[3:0], seed_sizes[e], 1'b0);
    end
    send_item(fpfa_pkg::OP_REQUEST, 4'd0, 16'd0, 1'b0);
    send_item(fpfa_pkg::OP_REQUEST, 4'd15, 16'hFFFF, 1'b0);
    send_item(fpfa_pkg::OP_REQUEST, 4'd0, 16'hFFFF, 1'b0);
    send_item(fpfa_pkg::OP_REQUEST, 4'd5, 16'd100, 1'b0);
    send_item(fpfa_pkg::OP_REQUEST, 4'd0, 16'd101, 1'b0);
    send_item(fpfa_pkg::OP_REQUEST, 4'd0, 16'd0, 1'b1);
    send_item(fpfa_pkg::OP_LOAD, 4'd2, 16'd1, 1'b1);

    // Random phases over fit modes, block counts and idling patterns
    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain();
      apb_write(AddrFitMode, 32'(phase_mode[ph]));
      apb_write(AddrBlockCnt, 32'(phase_count[ph]));
      send_idle_pct  = (ph % 4 == 1) ? 49 : (ph % 4 == 3) ? 14 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 49 : (ph % 4 == 3) ? 14 : 0;
      target = items_sent + PhaseItems;
      while (items_sent < target) run_sequence();
    end

    drain();
    if (sb.errors == 0 && sb.expected_grants.size() == 0) begin
      $display("fixed_partition_fit_allocator verification clean");
    end else begin
      $display("fixed_partition_fit_allocator verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/fpfa_pkg.sv
design/fpfa_fit_cmp.sv
design/fixed_partition_fit_allocator.sv
design/fpfa_checker.sv
bench/fixed_partition_fit_allocator_tb.sv
